>>> rtl/core/crpt_pkg.sv
// ----------------------------------------------------------------------------
// crpt_pkg
// Shared types, command codes and helpers of the correction priority table.
// ----------------------------------------------------------------------------
package crpt_pkg;

  // Command codes carried by a request beat
  localparam logic [1:0] CMD_ADD_LT   = 2'd0;
  localparam logic [1:0] CMD_ADD_FAST = 2'd1;
  localparam logic [1:0] CMD_QUERY    = 2'd2;
  localparam logic [1:0] CMD_CLEAR    = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LT_LIFE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_LIFE = 2'd1;

  localparam logic [15:0] LT_LIFE_RESET   = 16'd7200;
  localparam logic [15:0] FAST_LIFE_RESET = 16'd300;

  // Slots at or above this count are ignored
  localparam int SAT_SLOTS = 64;

  // IODP agreement scores
  localparam logic [1:0] SCORE_NONE    = 2'd0;
  localparam logic [1:0] SCORE_UNKNOWN = 2'd1;
  localparam logic [1:0] SCORE_MATCH   = 2'd2;

  typedef struct packed {
    logic [5:0]  sat;
    logic [31:0] start;
    logic [1:0]  iodp;
    logic        has_iodp;
    logic        vel;
    logic        mixed;
    logic [15:0] tag;
  } lt_entry_t;

  typedef struct packed {
    logic [5:0]  sat;
    logic [31:0] start;
    logic [1:0]  iodp;
  } fw_entry_t;

  typedef struct packed {
    logic        found;
    logic [15:0] best_tag;
    logic [1:0]  best_score;
    logic [31:0] best_start_s;
    logic        fast_found;
    logic [1:0]  fast_iodp;
    logic        insert_dropped;
  } result_t;

  // Live when start <= t < start + life, end computed without wrap
  function automatic logic is_live(input logic [31:0] start, input logic [15:0] life,
                                   input logic [31:0] t);
    logic [32:0] end_s;
    end_s = {1'b0, start} + {17'b0, life};
    return (t >= start) && ({1'b0, t} < end_s);
  endfunction

endpackage

>>> rtl/core/crpt_if.sv
// ----------------------------------------------------------------------------
// crpt_if
// Request and response channels of the correction priority table.
// ----------------------------------------------------------------------------
interface crpt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [5:0]  sat_slot;
  logic [31:0] time_s;
  logic [1:0]  iodp_value;
  logic        iodp_present;
  logic        with_velocity;
  logic        from_mixed;
  logic [15:0] payload_tag;

  modport source (output valid, cmd, sat_slot, time_s, iodp_value, iodp_present,
                  with_velocity, from_mixed, payload_tag, input ready);
  modport sink (input valid, cmd, sat_slot, time_s, iodp_value, iodp_present,
                with_velocity, from_mixed, payload_tag, output ready);
endinterface

interface crpt_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] best_tag;
  logic [1:0]  best_score;
  logic [31:0] best_start_s;
  logic        fast_found;
  logic [1:0]  fast_iodp;
  logic        insert_dropped;

  modport source (output valid, found, best_tag, best_score, best_start_s, fast_found,
                  fast_iodp, insert_dropped, input ready);
  modport sink (input valid, found, best_tag, best_score, best_start_s, fast_found,
                fast_iodp, insert_dropped, output ready);
endinterface

>>> rtl/core/crpt_ram.sv
// ----------------------------------------------------------------------------
// crpt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module crpt_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/crpt_seq.sv
// ----------------------------------------------------------------------------
// crpt_seq
// Command sequencer: table inserts, clear, and the two-pass query scan.
// ----------------------------------------------------------------------------
module crpt_seq import crpt_pkg::*; #(
  parameter int LONGTERM_DEPTH = 256,
  parameter int FAST_DEPTH = 64,
  localparam int LT_AW = $clog2(LONGTERM_DEPTH),
  localparam int FW_AW = $clog2(FAST_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  crpt_req_if.sink              request,
  crpt_rsp_if.source            response,
  output logic                  lt_wr_en,
  output logic [LT_AW-1:0]      lt_wr_addr,
  output lt_entry_t             lt_wr_data,
  output logic                  lt_rd_en,
  output logic [LT_AW-1:0]      lt_rd_addr,
  input  lt_entry_t             lt_rd_data,
  output logic                  fw_wr_en,
  output logic [FW_AW-1:0]      fw_wr_addr,
  output fw_entry_t             fw_wr_data,
  output logic                  fw_rd_en,
  output logic [FW_AW-1:0]      fw_rd_addr,
  input  fw_entry_t             fw_rd_data
);

  localparam int LT_CW = $clog2(LONGTERM_DEPTH + 1);
  localparam int FW_CW = $clog2(FAST_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FSCAN = 2'd1;
  localparam logic [1:0] ST_LSCAN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state;
  logic [15:0]      lt_life;
  logic [15:0]      fw_life;
  logic [LT_CW-1:0] lt_count;
  logic [FW_CW-1:0] fw_count;
  logic [LT_CW-1:0] lt_idx;
  logic [FW_CW-1:0] fw_idx;
  logic             lt_rv;
  logic             fw_rv;
  logic [5:0]       q_sat;
  logic [31:0]      q_time;
  logic             ffound;
  logic [1:0]       fiodp;
  logic             best_v;
  lt_entry_t        best;
  logic [1:0]       best_sc;
  logic             dropped;
  logic             rsp_v;
  result_t          rsp;

  logic             accept;
  logic             sat_ok;
  logic             lt_full;
  logic             fw_full;
  logic             fw_hit;
  logic             lt_cand;
  logic [1:0]       lt_score;
  logic             lt_better;

  // Lifetime registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lt_life <= LT_LIFE_RESET;
      fw_life <= FAST_LIFE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LT_LIFE:   lt_life <= cfg_data;
        CFG_FAST_LIFE: fw_life <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and insert decode
  assign request.ready = (state == ST_IDLE);
  assign accept  = request.valid && request.ready;
  assign sat_ok  = {1'b0, request.sat_slot} < 7'(SAT_SLOTS);
  assign lt_full = (lt_count == LT_CW'(LONGTERM_DEPTH));
  assign fw_full = (fw_count == FW_CW'(FAST_DEPTH));

  assign lt_wr_en   = accept && (request.cmd == CMD_ADD_LT) && sat_ok && !lt_full;
  assign lt_wr_addr = lt_count[LT_AW-1:0];
  assign lt_wr_data = '{sat: request.sat_slot, start: request.time_s,
                        iodp: request.iodp_value, has_iodp: request.iodp_present,
                        vel: request.with_velocity, mixed: request.from_mixed,
                        tag: request.payload_tag};

  assign fw_wr_en   = accept && (request.cmd == CMD_ADD_FAST) && sat_ok && !fw_full;
  assign fw_wr_addr = fw_count[FW_AW-1:0];
  assign fw_wr_data = '{sat: request.sat_slot, start: request.time_s,
                        iodp: request.iodp_value};

  // Scan read issue, one entry per cycle
  assign fw_rd_en   = (state == ST_FSCAN) && (fw_idx != fw_count);
  assign fw_rd_addr = fw_idx[FW_AW-1:0];
  assign lt_rd_en   = (state == ST_LSCAN) && (lt_idx != lt_count);
  assign lt_rd_addr = lt_idx[LT_AW-1:0];

  // Fast window match on returned read data
  assign fw_hit = fw_rv && (fw_rd_data.sat == q_sat) &&
                  is_live(fw_rd_data.start, fw_life, q_time);

  // Long-term candidate score and ranking against the current best
  assign lt_cand = lt_rv && (lt_rd_data.sat == q_sat) &&
                   is_live(lt_rd_data.start, lt_life, q_time);

  always_comb begin
    if (!lt_rd_data.has_iodp) begin
      lt_score = SCORE_NONE;
    end else if (ffound) begin
      lt_score = (lt_rd_data.iodp == fiodp) ? SCORE_MATCH : SCORE_NONE;
    end else begin
      lt_score = SCORE_UNKNOWN;
    end
  end

  always_comb begin
    if (lt_score != best_sc) begin
      lt_better = lt_score > best_sc;
    end else if (lt_rd_data.start != best.start) begin
      lt_better = lt_rd_data.start > best.start;
    end else if (lt_rd_data.vel != best.vel) begin
      lt_better = lt_rd_data.vel;
    end else if (lt_rd_data.mixed != best.mixed) begin
      lt_better = lt_rd_data.mixed;
    end else begin
      lt_better = 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      lt_count <= '0;
      fw_count <= '0;
      lt_rv    <= 1'b0;
      fw_rv    <= 1'b0;
      rsp_v    <= 1'b0;
    end else begin
      if (rsp_v && response.ready) begin
        rsp_v <= 1'b0;
      end
      fw_rv <= fw_rd_en;
      lt_rv <= lt_rd_en;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            q_sat   <= request.sat_slot;
            q_time  <= request.time_s;
            ffound  <= 1'b0;
            fiodp   <= '0;
            best_v  <= 1'b0;
            best_sc <= SCORE_NONE;
            dropped <= 1'b0;
            fw_idx  <= '0;
            lt_idx  <= '0;
            state   <= ST_DONE;
            case (request.cmd)
              CMD_ADD_LT: begin
                if (sat_ok) begin
                  if (lt_full) begin
                    dropped <= 1'b1;
                  end else begin
                    lt_count <= lt_count + 1'b1;
                  end
                end
              end
              CMD_ADD_FAST: begin
                if (sat_ok) begin
                  if (fw_full) begin
                    dropped <= 1'b1;
                  end else begin
                    fw_count <= fw_count + 1'b1;
                  end
                end
              end
              CMD_QUERY: begin
                if (sat_ok) begin
                  state <= ST_FSCAN;
                end
              end
              CMD_CLEAR: begin
                lt_count <= '0;
                fw_count <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_FSCAN: begin
          if (fw_rd_en) begin
            fw_idx <= fw_idx + 1'b1;
          end
          // Stop at the first live window, drop the read still in flight
          if (fw_hit) begin
            ffound <= 1'b1;
            fiodp  <= fw_rd_data.iodp;
            fw_rv  <= 1'b0;
            state  <= ST_LSCAN;
          end else if (!fw_rv && !fw_rd_en) begin
            state <= ST_LSCAN;
          end
        end
        ST_LSCAN: begin
          if (lt_rd_en) begin
            lt_idx <= lt_idx + 1'b1;
          end
          if (lt_cand && (!best_v || lt_better)) begin
            best    <= lt_rd_data;
            best_sc <= lt_score;
            best_v  <= 1'b1;
          end
          if (!lt_rv && !lt_rd_en) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hand the result to the output register once it is free
          if (!rsp_v || response.ready) begin
            rsp_v <= 1'b1;
            rsp   <= '{found: best_v,
                       best_tag: best_v ? best.tag : 16'd0,
                       best_score: best_v ? best_sc : SCORE_NONE,
                       best_start_s: best_v ? best.start : 32'd0,
                       fast_found: ffound,
                       fast_iodp: fiodp,
                       insert_dropped: dropped};
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  assign response.valid          = rsp_v;
  assign response.found          = rsp.found;
  assign response.best_tag       = rsp.best_tag;
  assign response.best_score     = rsp.best_score;
  assign response.best_start_s   = rsp.best_start_s;
  assign response.fast_found     = rsp.fast_found;
  assign response.fast_iodp      = rsp.fast_iodp;
  assign response.insert_dropped = rsp.insert_dropped;

  // Checks
  a_lt_count_bound: assert property (@(posedge clk) disable iff (rst)
    lt_count <= LT_CW'(LONGTERM_DEPTH))
    else $error("long-term count beyond depth");

  a_fw_count_bound: assert property (@(posedge clk) disable iff (rst)
    fw_count <= FW_CW'(FAST_DEPTH))
    else $error("fast count beyond depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !request.ready)
    else $error("request taken while a command is in progress");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_v && !rsp.found) |-> (rsp.best_tag == 16'd0 && rsp.best_score == SCORE_NONE &&
                               rsp.best_start_s == 32'd0))
    else $error("result fields set without a found entry");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    rsp_v |-> (rsp.best_score == SCORE_NONE || rsp.best_score == SCORE_UNKNOWN ||
               rsp.best_score == SCORE_MATCH))
    else $error("score out of range");

  a_drop_only_on_add: assert property (@(posedge clk) disable iff (rst)
    (rsp_v && rsp.insert_dropped) |-> (!rsp.found && !rsp.fast_found))
    else $error("drop flag on a query result");

endmodule

>>> rtl/core/correction_priority_table.sv
// ----------------------------------------------------------------------------
// correction_priority_table
// Long-term correction table and fast-window table with a ranked query.
// ----------------------------------------------------------------------------
// One command is in progress at a time. An add or a clear passes from the accepted
// request beat through the done state to the output register. A query reads the
// fast table one entry a cycle until the first live window of the satellite, then
// reads every stored long-term entry one a cycle. The single read port of each
// table memory sets that scan rate. A finished result waits in an output register
// while the next request is taken. The user must write both lifetime registers
// only while no command is in progress; the block itself does not enforce it.
module correction_priority_table import crpt_pkg::*; #(
  parameter int LONGTERM_DEPTH = 256,
  parameter int FAST_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  crpt_req_if.sink              request,
  crpt_rsp_if.source            response
);

  localparam int LT_AW = $clog2(LONGTERM_DEPTH);
  localparam int FW_AW = $clog2(FAST_DEPTH);

  logic             lt_wr_en;
  logic [LT_AW-1:0] lt_wr_addr;
  lt_entry_t        lt_wr_data;
  logic             lt_rd_en;
  logic [LT_AW-1:0] lt_rd_addr;
  lt_entry_t        lt_rd_data;
  logic             fw_wr_en;
  logic [FW_AW-1:0] fw_wr_addr;
  fw_entry_t        fw_wr_data;
  logic             fw_rd_en;
  logic [FW_AW-1:0] fw_rd_addr;
  fw_entry_t        fw_rd_data;

  // Command sequencer
  crpt_seq #(
    .LONGTERM_DEPTH (LONGTERM_DEPTH),
    .FAST_DEPTH     (FAST_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .request    (request),
    .response   (response),
    .lt_wr_en   (lt_wr_en),
    .lt_wr_addr (lt_wr_addr),
    .lt_wr_data (lt_wr_data),
    .lt_rd_en   (lt_rd_en),
    .lt_rd_addr (lt_rd_addr),
    .lt_rd_data (lt_rd_data),
    .fw_wr_en   (fw_wr_en),
    .fw_wr_addr (fw_wr_addr),
    .fw_wr_data (fw_wr_data),
    .fw_rd_en   (fw_rd_en),
    .fw_rd_addr (fw_rd_addr),
    .fw_rd_data (fw_rd_data)
  );

  // Long-term entry memory
  crpt_ram #(
    .WIDTH ($bits(lt_entry_t)),
    .DEPTH (LONGTERM_DEPTH)
  ) u_lt_ram (
    .clk     (clk),
    .wr_en   (lt_wr_en),
    .wr_addr (lt_wr_addr),
    .wr_data (lt_wr_data),
    .rd_en   (lt_rd_en),
    .rd_addr (lt_rd_addr),
    .rd_data (lt_rd_data)
  );

  // Fast window memory
  crpt_ram #(
    .WIDTH ($bits(fw_entry_t)),
    .DEPTH (FAST_DEPTH)
  ) u_fw_ram (
    .clk     (clk),
    .wr_en   (fw_wr_en),
    .wr_addr (fw_wr_addr),
    .wr_data (fw_wr_data),
    .rd_en   (fw_rd_en),
    .rd_addr (fw_rd_addr),
    .rd_data (fw_rd_data)
  );

endmodule
